### rtl/ddd_pkg.sv
// Shared types and constants for the dataflow dependency depth scoreboard.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package ddd_pkg;

    // Field widths fixed by the instruction and result formats
    localparam int OPC_W     = 3;
    localparam int REG_W     = 5;
    localparam int LAT_W     = 8;
    localparam int IDX_W     = 12;
    localparam int DEP_W     = 13;
    localparam int DEPTH_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 80;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [DEP_W-1:0]   DEP_NONE  = '1;  // -1: source has no writer

    // Table update issued by the compute stage
    typedef struct packed {
        logic               en;
        logic               clear;
        logic [REG_W-1:0]   dest;
        logic [IDX_W-1:0]   writer;
        logic [DEPTH_W-1:0] finish;
    } tbl_wr_t;

    // Resolved lookup of one source register
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   writer;
        logic [DEPTH_W-1:0] finish;
    } tbl_rd_t;

endpackage

`default_nettype wire

### rtl/ddd_lat_regs.sv
// Per-opcode latency registers and the latency lookup for the compute stage.
// Depends on ddd_pkg.
`default_nettype none

module ddd_lat_regs #(
    parameter int NUM_OPCODES = 8
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire [ddd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [ddd_pkg::LAT_W-1:0]        cfg_data,
    input  wire [ddd_pkg::OPC_W-1:0]        opcode,
    output logic [ddd_pkg::LAT_W-1:0]       lat
);
    import ddd_pkg::*;

    localparam int LW = (NUM_OPCODES > 1) ? $clog2(NUM_OPCODES) : 1;

    logic [LAT_W-1:0] lat_reg [NUM_OPCODES];

    // Take a register write; indexes past the opcode count are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_OPCODES; i++) begin
                lat_reg[i] <= LAT_W'(1);
            end
        end else if (cfg_we && (32'(cfg_index) < NUM_OPCODES)) begin
            lat_reg[cfg_index[LW-1:0]] <= cfg_data;
        end
    end

    // Opcodes without a register take zero latency
    always_comb begin
        if (32'(opcode) < NUM_OPCODES) begin
            lat = lat_reg[opcode[LW-1:0]];
        end else begin
            lat = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/ddd_table.sv
// Last-writer table: valid flip-flops, writer/finish memory with two
// registered read ports, and forwarding of the write at the read edge.
// Depends on ddd_pkg.
`default_nettype none

module ddd_table #(
    parameter int NUM_REGS = 32
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         rd_en,
    input  wire [ddd_pkg::REG_W-1:0]    src1,
    input  wire [ddd_pkg::REG_W-1:0]    src2,
    input  ddd_pkg::tbl_wr_t            wr,
    output ddd_pkg::tbl_rd_t            rd1,
    output ddd_pkg::tbl_rd_t            rd2
);
    import ddd_pkg::*;

    localparam int SPAN      = 1 << REG_W;
    localparam int TBL_DEPTH = (NUM_REGS < SPAN) ? NUM_REGS : SPAN;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int DW        = IDX_W + DEPTH_W;

    logic [DW-1:0]        mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] valid_reg;
    logic [DW-1:0]        rdata1_reg, rdata2_reg, byp_reg;
    logic                 hit1_reg, hit2_reg, vld1_reg, vld2_reg;

    logic src1_ok, src2_ok, dest_ok, wr_hit, hit1, hit2, clr;

    assign src1_ok = 32'(src1) < NUM_REGS;
    assign src2_ok = 32'(src2) < NUM_REGS;
    assign dest_ok = 32'(wr.dest) < NUM_REGS;
    assign wr_hit  = wr.en && !wr.clear && dest_ok;
    assign clr     = wr.en && wr.clear;
    assign hit1    = wr_hit && (wr.dest == src1);
    assign hit2    = wr_hit && (wr.dest == src2);

    // Set the written entry's valid bit; drop them all at end of trace
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr) begin
            valid_reg <= '0;
        end else if (wr_hit) begin
            valid_reg[wr.dest[AW-1:0]] <= 1'b1;
        end
    end

    // Memory write and registered reads
    always_ff @(posedge aclk) begin
        if (wr.en && dest_ok) begin
            mem[wr.dest[AW-1:0]] <= {wr.writer, wr.finish};
        end
        if (rd_en) begin
            rdata1_reg <= mem[src1[AW-1:0]];
            rdata2_reg <= mem[src2[AW-1:0]];
            byp_reg    <= {wr.writer, wr.finish};
        end
    end

    // Lookup flags, with the same-edge write forwarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit1_reg <= 1'b0;
            hit2_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (rd_en) begin
            hit1_reg <= hit1;
            hit2_reg <= hit2;
            vld1_reg <= !clr && src1_ok && (hit1 || valid_reg[src1[AW-1:0]]);
            vld2_reg <= !clr && src2_ok && (hit2 || valid_reg[src2[AW-1:0]]);
        end
    end

    // Pick forwarded or stored data
    always_comb begin
        rd1.valid                 = vld1_reg;
        {rd1.writer, rd1.finish}  = hit1_reg ? byp_reg : rdata1_reg;
        rd2.valid                 = vld2_reg;
        {rd2.writer, rd2.finish}  = hit2_reg ? byp_reg : rdata2_reg;
    end

endmodule

`default_nettype wire

### rtl/dataflow_dependency_depth.sv
// Top level of the dataflow dependency depth scoreboard: lookup stage,
// compute stage and result register. Depends on ddd_pkg, ddd_lat_regs, ddd_table.
//
//   channel  direction  handshake               payload
//   s_       in         s_tvalid / s_tready     s_tdata (24), s_tlast
//   m_       out        m_tvalid / m_tready     m_tdata (80), m_tlast
//   cfg_     in         cfg_valid / cfg_ready   cfg_index (3), cfg_data (8)
//
// One instruction per cycle sustained while the result is not stalled; a result is registered
// in two steps after its instruction is taken: table memory read, then compute into the result register.
// The table read forwards the write made at the same edge.
// Reset (aresetn low, synchronous) clears valid bits, counters, and sets latencies to 1.
// A stalled result holds the compute stage; input is refused only while both are full.
`default_nettype none

module dataflow_dependency_depth #(
    parameter int NUM_REGS    = 32,
    parameter int MAX_INSTS   = 4096,
    parameter int NUM_OPCODES = 8
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // opcode[2:0], dest_reg[7:3], src1_reg[12:8], src2_reg[17:13], zero[23:18]
    input  wire [ddd_pkg::IN_W-1:0]         s_tdata,
    input  wire                             s_tlast,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // inst_index[11:0], src1_dependency[24:12], src2_dependency[37:25],
    // inst_depth[57:38], program_depth[77:58], zero[79:78]
    output logic [ddd_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [ddd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [ddd_pkg::LAT_W-1:0]        cfg_data
);
    import ddd_pkg::*;

    localparam int CW = $clog2(MAX_INSTS);

    logic             s1_valid_reg, s1_last_reg;
    logic [OPC_W-1:0] s1_opcode_reg;
    logic [REG_W-1:0] s1_dest_reg;
    logic [CW-1:0]    counter_reg;
    logic [DEPTH_W-1:0] max_finish_reg;

    logic               m_valid_reg, m_last_reg;
    logic [IDX_W-1:0]   m_index_reg;
    logic [DEP_W-1:0]   m_dep1_reg, m_dep2_reg;
    logic [DEPTH_W-1:0] m_depth_reg, m_prog_reg;

    logic accept, s1_adv;
    logic [LAT_W-1:0]   lat;
    tbl_wr_t            wr;
    tbl_rd_t            rd1, rd2;
    logic [DEPTH_W-1:0] d1, d2, depth, finish, max_finish_next;
    logic [DEPTH_W:0]   sum;
    logic [CW-1:0]      counter_next;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;

    ddd_lat_regs #(.NUM_OPCODES(NUM_OPCODES)) u_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .opcode    (s1_opcode_reg),
        .lat       (lat)
    );

    ddd_table #(.NUM_REGS(NUM_REGS)) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .src1    (s_tdata[12:8]),
        .src2    (s_tdata[17:13]),
        .wr      (wr),
        .rd1     (rd1),
        .rd2     (rd2)
    );

    // Start time, saturating finish time, running maximum
    always_comb begin
        d1     = rd1.valid ? rd1.finish : '0;
        d2     = rd2.valid ? rd2.finish : '0;
        depth  = (d1 > d2) ? d1 : d2;
        sum    = {1'b0, depth} + (DEPTH_W + 1)'(lat);
        finish = sum[DEPTH_W] ? DEPTH_MAX : sum[DEPTH_W-1:0];
        max_finish_next = (finish > max_finish_reg) ? finish : max_finish_reg;
        counter_next    = (counter_reg == CW'(MAX_INSTS - 1)) ? '0 : counter_reg + 1'b1;

        wr.en     = s1_adv;
        wr.clear  = s1_last_reg;
        wr.dest   = s1_dest_reg;
        wr.writer = IDX_W'(counter_reg);
        wr.finish = finish;
    end

    // Lookup stage holds the instruction while its table read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (accept) begin
            s1_opcode_reg <= s_tdata[2:0];
            s1_dest_reg   <= s_tdata[7:3];
            s1_last_reg   <= s_tlast;
        end
    end

    // Trace position and program depth; restart after the last instruction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg    <= '0;
            max_finish_reg <= '0;
        end else if (s1_adv) begin
            counter_reg    <= s1_last_reg ? '0 : counter_next;
            max_finish_reg <= s1_last_reg ? '0 : max_finish_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (s1_adv) begin
            m_index_reg <= IDX_W'(counter_reg);
            m_dep1_reg  <= rd1.valid ? {1'b0, rd1.writer} : DEP_NONE;
            m_dep2_reg  <= rd2.valid ? {1'b0, rd2.writer} : DEP_NONE;
            m_depth_reg <= depth;
            m_prog_reg  <= max_finish_next;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_prog_reg, m_depth_reg, m_dep2_reg, m_dep1_reg, m_index_reg};

endmodule

`default_nettype wire

### rtl/ddd_checker.sv
// Port-level checks for dataflow_dependency_depth, attached by bind.
// Depends on ddd_pkg and the top level's port list.
`default_nettype none

module ddd_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tready,
    input wire [ddd_pkg::OUT_W-1:0]     m_tdata,
    input wire                          m_tlast,
    input wire                          m_tvalid,
    input wire                          m_tready
);
    import ddd_pkg::*;

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Restart numbering after the last instruction of a trace
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[11:0] == '0))
        else $error("index not restarted after end of trace");

    // Program depth never trails the instruction's start time
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[57:38] <= m_tdata[77:58])
        else $error("inst_depth above program_depth");

    // Refuse input only when the result side is stalled
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without output stall");

endmodule

bind dataflow_dependency_depth ddd_checker u_ddd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
